@@ rtl/core/sgc_pkg.sv @@
// ----------------------------------------------------------------------------
// sgc_pkg: shared types and constants of the swipe gesture classifier
// Holds the phase and direction codes, the classified-sample record passed
// from the front end to the back end, and the configuration defaults.
// ----------------------------------------------------------------------------
package sgc_pkg;

  localparam int unsigned COUNT_W         = 8;
  localparam int unsigned DIR_W           = 3;
  localparam int unsigned PHASE_W         = 4;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 8'd30;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE   = 4'd0,
    PH_WAIT   = 4'd1,
    PH_WAIT2  = 4'd2,
    PH_RIGHT1 = 4'd3,
    PH_RIGHT2 = 4'd4,
    PH_LEFT1  = 4'd5,
    PH_LEFT2  = 4'd6,
    PH_UP1    = 4'd7,
    PH_UP2    = 4'd8,
    PH_DOWN1  = 4'd9,
    PH_DOWN2  = 4'd10
  } phase_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE  = 3'd0,
    DIR_RIGHT = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_UP    = 3'd3,
    DIR_DOWN  = 3'd4
  } dir_t;

  // Everything the state machine needs to know about one sample.
  typedef struct packed {
    logic cov_none;   // no channel over threshold
    logic cov_all;    // all four channels over threshold
    logic up_max;     // up strictly largest
    logic down_max;
    logic left_max;
    logic right_max;
    logic up_min;     // up strictly smallest
    logic down_min;
    logic left_min;
    logic right_min;
    logic last;       // copy of burst_last
  } class_t;

endpackage

@@ rtl/core/sgc_front.sv @@
// ----------------------------------------------------------------------------
// sgc_front: sample classifier
// Holds the presence threshold, accepts samples and registers the coverage
// and strict-extremum flags of each one for the queue.
// ----------------------------------------------------------------------------
module sgc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sgc_pkg::COUNT_W-1:0]   in_up_count,
  input  logic [sgc_pkg::COUNT_W-1:0]   in_down_count,
  input  logic [sgc_pkg::COUNT_W-1:0]   in_left_count,
  input  logic [sgc_pkg::COUNT_W-1:0]   in_right_count,
  input  logic                          in_burst_last,
  input  logic                          cfg_we,
  input  logic [sgc_pkg::COUNT_W-1:0]   cfg_data,
  output logic                          cls_valid,
  output sgc_pkg::class_t               cls_data,
  input  logic                          cls_ready
);
  import sgc_pkg::*;

  logic [COUNT_W-1:0] thr_r;
  logic               valid_r, valid_nxt;
  class_t             cls_r, cls_nxt;
  logic               accept;
  logic               up_cov, down_cov, left_cov, right_cov;

  assign in_stall = valid_r && !cls_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    up_cov    = in_up_count    > thr_r;
    down_cov  = in_down_count  > thr_r;
    left_cov  = in_left_count  > thr_r;
    right_cov = in_right_count > thr_r;

    cls_nxt.cov_none  = !(up_cov || down_cov || left_cov || right_cov);
    cls_nxt.cov_all   = up_cov && down_cov && left_cov && right_cov;
    cls_nxt.up_max    = (in_up_count > in_down_count) && (in_up_count > in_left_count)
                        && (in_up_count > in_right_count);
    cls_nxt.down_max  = (in_down_count > in_up_count) && (in_down_count > in_left_count)
                        && (in_down_count > in_right_count);
    cls_nxt.left_max  = (in_left_count > in_up_count) && (in_left_count > in_down_count)
                        && (in_left_count > in_right_count);
    cls_nxt.right_max = (in_right_count > in_up_count) && (in_right_count > in_down_count)
                        && (in_right_count > in_left_count);
    cls_nxt.up_min    = (in_up_count < in_down_count) && (in_up_count < in_left_count)
                        && (in_up_count < in_right_count);
    cls_nxt.down_min  = (in_down_count < in_up_count) && (in_down_count < in_left_count)
                        && (in_down_count < in_right_count);
    cls_nxt.left_min  = (in_left_count < in_up_count) && (in_left_count < in_down_count)
                        && (in_left_count < in_right_count);
    cls_nxt.right_min = (in_right_count < in_up_count) && (in_right_count < in_down_count)
                        && (in_right_count < in_left_count);
    cls_nxt.last      = in_burst_last;
  end

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (cls_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THRESHOLD_RESET;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (cfg_we) begin
        thr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cls_r <= cls_nxt;
    end
  end

  assign cls_valid = valid_r;
  assign cls_data  = cls_r;

`ifndef SYNTHESIS
  // A classified item that the queue refused must still be there, unchanged.
  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !cls_ready) |=> (valid_r && $stable(cls_r)))
    else $error("front item lost or changed while the queue was full");
`endif

endmodule

@@ rtl/core/sgc_queue.sv @@
// ----------------------------------------------------------------------------
// sgc_queue: short FIFO between the classifier and the state machine
// Lets the front end keep accepting samples while the back end is stalled.
// ----------------------------------------------------------------------------
module sgc_queue #(
  parameter int unsigned Width = 11,
  parameter int unsigned Depth = sgc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [Width-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [Width-1:0] pop_data
);
  import sgc_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = cnt_r != CntW'(Depth);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(Depth))
    else $error("queue fill count beyond depth");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CntW'(1) && pop && !push) |=> !pop_valid)
    else $error("queue not empty after last item was taken");
`endif

endmodule

@@ rtl/core/sgc_back.sv @@
// ----------------------------------------------------------------------------
// sgc_back: swipe state machine and result register
// Applies one classified sample per cycle to the gesture state unless the
// output stalls, and holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module sgc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cls_valid,
  output logic                        cls_ready,
  input  sgc_pkg::class_t             cls_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sgc_pkg::DIR_W-1:0]   out_direction,
  output logic [sgc_pkg::PHASE_W-1:0] out_phase,
  output logic                        out_result_last
);
  import sgc_pkg::*;

  phase_t phase_r, phase_nxt;
  dir_t   dir_r, dir_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   last_r;
  logic   take, pop;

  assign take      = !out_valid_r || !out_stall;
  assign cls_ready = take;
  assign pop       = cls_valid && take;

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_WAIT, PH_WAIT2: begin
        if (cls_data.cov_none) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_RIGHT1: begin
        if (cls_data.cov_none) begin
          phase_nxt = PH_WAIT;
        end else if (cls_data.cov_all) begin
          phase_nxt = PH_RIGHT2;
        end
      end
      PH_LEFT1: begin
        if (cls_data.cov_none) begin
          phase_nxt = PH_WAIT;
        end else if (cls_data.cov_all) begin
          phase_nxt = PH_LEFT2;
        end
      end
      PH_UP1: begin
        if (cls_data.cov_none) begin
          phase_nxt = PH_WAIT;
        end else if (cls_data.cov_all) begin
          phase_nxt = PH_UP2;
        end
      end
      PH_DOWN1: begin
        if (cls_data.cov_none) begin
          phase_nxt = PH_WAIT;
        end else if (cls_data.cov_all) begin
          phase_nxt = PH_DOWN2;
        end
      end
      PH_RIGHT2: begin
        if (!cls_data.cov_all) begin
          phase_nxt = cls_data.left_min ? PH_WAIT2 : PH_WAIT;
        end
      end
      PH_LEFT2: begin
        if (!cls_data.cov_all) begin
          phase_nxt = cls_data.right_min ? PH_WAIT2 : PH_WAIT;
        end
      end
      PH_UP2: begin
        if (!cls_data.cov_all) begin
          phase_nxt = cls_data.down_min ? PH_WAIT2 : PH_WAIT;
        end
      end
      PH_DOWN2: begin
        if (!cls_data.cov_all) begin
          phase_nxt = cls_data.up_min ? PH_WAIT2 : PH_WAIT;
        end
      end
      default: begin
        // Idle, and any unused code behaves as idle.
        phase_nxt = PH_IDLE;
        if (!cls_data.cov_none) begin
          if (cls_data.up_max) begin
            phase_nxt = PH_DOWN1;
          end else if (cls_data.down_max) begin
            phase_nxt = PH_UP1;
          end else if (cls_data.left_max) begin
            phase_nxt = PH_RIGHT1;
          end else if (cls_data.right_max) begin
            phase_nxt = PH_LEFT1;
          end else if (cls_data.cov_all) begin
            phase_nxt = PH_WAIT;
          end
        end
      end
    endcase
  end

  // Held direction.
  always_comb begin
    dir_nxt = dir_r;
    if (phase_r == PH_WAIT || phase_nxt == PH_WAIT) begin
      dir_nxt = DIR_NONE;
    end else if (phase_nxt == PH_WAIT2) begin
      unique case (phase_r)
        PH_RIGHT2: dir_nxt = DIR_RIGHT;
        PH_LEFT2:  dir_nxt = DIR_LEFT;
        PH_UP2:    dir_nxt = DIR_UP;
        PH_DOWN2:  dir_nxt = DIR_DOWN;
        default:   dir_nxt = dir_r;
      endcase
    end
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      dir_r       <= DIR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        phase_r <= phase_nxt;
        dir_r   <= dir_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      last_r <= cls_data.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_direction   = dir_r;
  assign out_phase       = phase_r;
  assign out_result_last = last_r;

`ifndef SYNTHESIS
  a_wait_clears_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WAIT) |-> (dir_r == DIR_NONE))
    else $error("direction held while in wait");

  a_wait2_releases: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && phase_r == PH_WAIT2 && cls_data.cov_none) |=> (phase_r == PH_IDLE))
    else $error("reported wait did not return to idle on an empty sample");
`endif

endmodule

@@ rtl/core/swipe_gesture_classifier_core.sv @@
// ----------------------------------------------------------------------------
// swipe_gesture_classifier_core: swipe gesture classifier, top level
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  up/down/left/right counts, burst_last
//   out      output     out_valid/out_stall direction, phase, result_last
//   cfg      input      cfg_valid/cfg_ready presence threshold (8 bit)
//
// One item is accepted per cycle sustained while the output is not stalled;
// every item gives exactly one result, passing in order through the
// classifier register, the queue and the result register.
// The state machine update is the feedback loop that sets this rate.
// Reset is synchronous: the machine returns to idle with no direction held
// and the threshold goes back to 30.
// A stall on the output fills the queue first; in_stall rises only once the
// queue and the classifier register are both full.
// The threshold write port is always ready and takes effect on the next item.
// ----------------------------------------------------------------------------
module swipe_gesture_classifier_core #(
  parameter int unsigned QueueDepth = sgc_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sgc_pkg::COUNT_W-1:0] in_up_count,
  input  logic [sgc_pkg::COUNT_W-1:0] in_down_count,
  input  logic [sgc_pkg::COUNT_W-1:0] in_left_count,
  input  logic [sgc_pkg::COUNT_W-1:0] in_right_count,
  input  logic                        in_burst_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sgc_pkg::DIR_W-1:0]   out_direction,
  output logic [sgc_pkg::PHASE_W-1:0] out_phase,
  output logic                        out_result_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sgc_pkg::COUNT_W-1:0] cfg_presence_threshold
);
  import sgc_pkg::*;

  localparam int unsigned ClsW = $bits(class_t);

  logic   front_valid, front_ready;
  class_t front_data;
  logic   back_valid, back_ready;
  class_t back_data;

  // The threshold register lives in the classifier; writes are never held.
  assign cfg_ready = 1'b1;

  // Front end: threshold compares and strict max/min flags, registered.
  sgc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_up_count    (in_up_count),
    .in_down_count  (in_down_count),
    .in_left_count  (in_left_count),
    .in_right_count (in_right_count),
    .in_burst_last  (in_burst_last),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_presence_threshold),
    .cls_valid      (front_valid),
    .cls_data       (front_data),
    .cls_ready      (front_ready)
  );

  // Queue decouples the classifier from the state machine.
  sgc_queue #(
    .Width (ClsW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_data),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_data)
  );

  // Back end: swipe state machine and result register.
  sgc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cls_valid       (back_valid),
    .cls_ready       (back_ready),
    .cls_data        (back_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_direction   (out_direction),
    .out_phase       (out_phase),
    .out_result_last (out_result_last)
  );

endmodule
